FILE: rtl/core/crt_pkg.sv
`timescale 1ns / 1ps

package crt_pkg;

  localparam int MODULUS_BITS_DEF  = 32;
  localparam int COMBINED_BITS_DEF = 63;
  localparam int DW                = 64;   // divider dividend width

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_NOSOL = 2'd1;
  localparam logic [1:0] STAT_OVF   = 2'd2;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_RED, OP_SEED, OP_GCD_INIT, OP_GCD, OP_RD_R, OP_RD_CMP,
    OP_SET_NOSOL, OP_MD, OP_MM, OP_LCM_LO, OP_LCM_HI, OP_LCM_SUM, OP_SET_OVF,
    OP_RM, OP_DIFF, OP_Q, OP_KZERO, OP_INV0, OP_EUC_DIV, OP_EUC_MUL, OP_EUC_UPD,
    OP_INV_FIX, OP_K_MUL, OP_K_DIV, OP_KM_LO, OP_KM_HI, OP_COMMIT, OP_EMIT
  } op_t;

  typedef enum logic [5:0] {
    S_IDLE, S_RED, S_BRANCH, S_SEED, S_GCD_INIT, S_GCD, S_RD_R, S_RD_CMP, S_CHK1,
    S_NOSOL, S_MD, S_MM, S_LCM_LO, S_LCM_HI, S_LCM_SUM, S_CHK2, S_OVF, S_RM,
    S_DIFF, S_Q, S_CHK3, S_KZERO, S_INV0, S_EUC_DIV, S_EUC_MUL, S_EUC_UPD,
    S_INV_FIX, S_K_MUL, S_K_DIV, S_KM_LO, S_KM_HI, S_COMMIT, S_FIN, S_EMIT
  } state_t;

  typedef struct packed {
    op_t  op;
    logic div_start;
  } ctl_t;

  typedef struct packed {
    logic div_done;
    logic rem_zero;   // divider remainder is zero
    logic t_zero;
    logic in_system;
    logic sticky_ok;
    logic nosol;
    logic ovf;
    logic mm_le1;
    logic last;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/core/crt_div.sv
`timescale 1ns / 1ps

module crt_div
  import crt_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [31:0]   divisor,
  output logic [DW-1:0] quo,
  output logic [31:0]   rem,
  output logic          done
);

  localparam int CW = $clog2(DW);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [32:0]   acc;
  logic [DW-1:0] qr;
  logic [32:0]   sh;
  logic          wide;

  assign wide = dividend[DW-1:32] != '0;
  assign sh   = {acc[31:0], qr[DW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        acc  <= '0;
        // narrow dividend: only the low word is walked
        if (wide) begin
          qr  <= dividend;
          cnt <= CW'(DW - 1);
        end else begin
          qr  <= {dividend[31:0], 32'b0};
          cnt <= CW'(31);
        end
      end else if (busy) begin
        if (sh >= {1'b0, divisor}) begin
          acc <= sh - {1'b0, divisor};
          qr  <= {qr[DW-2:0], 1'b1};
        end else begin
          acc <= sh;
          qr  <= {qr[DW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo = qr;
  assign rem = acc[31:0];

endmodule

FILE: rtl/core/crt_ctrl.sv
`timescale 1ns / 1ps

module crt_ctrl
  import crt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  sts_t sts,
  output ctl_t ctl
);

  state_t state, state_next;
  logic   issued, is_div;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      issued <= 1'b0;
    end else begin
      state <= state_next;
      if (sts.div_done) issued <= 1'b0;
      else if (ctl.div_start) issued <= 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:     if (s_tvalid) state_next = S_RED;
      S_RED:      if (sts.div_done) state_next = S_BRANCH;
      S_BRANCH: begin
        if (!sts.in_system) state_next = S_SEED;
        else if (!sts.sticky_ok) state_next = S_FIN;
        else state_next = S_GCD_INIT;
      end
      S_SEED:     state_next = S_FIN;
      S_GCD_INIT: state_next = S_GCD;
      S_GCD:      if (sts.div_done && sts.rem_zero) state_next = S_RD_R;
      S_RD_R:     if (sts.div_done) state_next = S_RD_CMP;
      S_RD_CMP:   if (sts.div_done) state_next = S_CHK1;
      S_CHK1:     state_next = sts.nosol ? S_NOSOL : S_MD;
      S_NOSOL:    state_next = S_FIN;
      S_MD:       if (sts.div_done) state_next = S_MM;
      S_MM:       if (sts.div_done) state_next = S_LCM_LO;
      S_LCM_LO:   state_next = S_LCM_HI;
      S_LCM_HI:   state_next = S_LCM_SUM;
      S_LCM_SUM:  state_next = S_CHK2;
      S_CHK2:     state_next = sts.ovf ? S_OVF : S_RM;
      S_OVF:      state_next = S_FIN;
      S_RM:       if (sts.div_done) state_next = S_DIFF;
      S_DIFF:     state_next = S_Q;
      S_Q:        if (sts.div_done) state_next = S_CHK3;
      S_CHK3:     state_next = sts.mm_le1 ? S_KZERO : S_INV0;
      S_KZERO:    state_next = S_KM_LO;
      S_INV0:     if (sts.div_done) state_next = S_EUC_DIV;
      S_EUC_DIV:  if (sts.div_done) state_next = S_EUC_MUL;
      S_EUC_MUL:  state_next = S_EUC_UPD;
      S_EUC_UPD:  state_next = sts.t_zero ? S_INV_FIX : S_EUC_DIV;
      S_INV_FIX:  state_next = S_K_MUL;
      S_K_MUL:    state_next = S_K_DIV;
      S_K_DIV:    if (sts.div_done) state_next = S_KM_LO;
      S_KM_LO:    state_next = S_KM_HI;
      S_KM_HI:    state_next = S_COMMIT;
      S_COMMIT:   state_next = S_FIN;
      S_FIN:      state_next = sts.last ? S_EMIT : S_IDLE;
      S_EMIT:     if (sts.out_free) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctl.op   = OP_NONE;
    is_div   = 1'b0;
    s_tready = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) ctl.op = OP_LOAD;
      end
      S_RED:      begin ctl.op = OP_RED;     is_div = 1'b1; end
      S_SEED:     ctl.op = OP_SEED;
      S_GCD_INIT: ctl.op = OP_GCD_INIT;
      S_GCD:      begin ctl.op = OP_GCD;     is_div = 1'b1; end
      S_RD_R:     begin ctl.op = OP_RD_R;    is_div = 1'b1; end
      S_RD_CMP:   begin ctl.op = OP_RD_CMP;  is_div = 1'b1; end
      S_NOSOL:    ctl.op = OP_SET_NOSOL;
      S_MD:       begin ctl.op = OP_MD;      is_div = 1'b1; end
      S_MM:       begin ctl.op = OP_MM;      is_div = 1'b1; end
      S_LCM_LO:   ctl.op = OP_LCM_LO;
      S_LCM_HI:   ctl.op = OP_LCM_HI;
      S_LCM_SUM:  ctl.op = OP_LCM_SUM;
      S_OVF:      ctl.op = OP_SET_OVF;
      S_RM:       begin ctl.op = OP_RM;      is_div = 1'b1; end
      S_DIFF:     ctl.op = OP_DIFF;
      S_Q:        begin ctl.op = OP_Q;       is_div = 1'b1; end
      S_KZERO:    ctl.op = OP_KZERO;
      S_INV0:     begin ctl.op = OP_INV0;    is_div = 1'b1; end
      S_EUC_DIV:  begin ctl.op = OP_EUC_DIV; is_div = 1'b1; end
      S_EUC_MUL:  ctl.op = OP_EUC_MUL;
      S_EUC_UPD:  ctl.op = OP_EUC_UPD;
      S_INV_FIX:  ctl.op = OP_INV_FIX;
      S_K_MUL:    ctl.op = OP_K_MUL;
      S_K_DIV:    begin ctl.op = OP_K_DIV;   is_div = 1'b1; end
      S_KM_LO:    ctl.op = OP_KM_LO;
      S_KM_HI:    ctl.op = OP_KM_HI;
      S_COMMIT:   ctl.op = OP_COMMIT;
      S_EMIT:     if (sts.out_free) ctl.op = OP_EMIT;
      default:    ctl.op = OP_NONE;
    endcase
    ctl.div_start = is_div && !issued && !sts.div_done;
  end

endmodule

FILE: rtl/core/crt_dpath.sv
`timescale 1ns / 1ps

module crt_dpath
  import crt_pkg::*;
#(
  parameter int MODULUS_BITS  = MODULUS_BITS_DEF,
  parameter int COMBINED_BITS = COMBINED_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  ctl_t        ctl,
  output sts_t        sts,
  input  logic [63:0] s_tdata,
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata
);

  localparam int CB = COMBINED_BITS;

  // combined state
  logic [CB-1:0] cm, cr, md, lcm;
  logic          in_system;
  logic [1:0]    sticky;
  // per-item work registers
  logic [31:0]   m, r, d, mm, q, qq, k, t, a1;
  logic [DW-1:0] a0;
  logic          last, nosol, ovf;
  logic signed [33:0] s0, s1;
  logic [63:0]   prod_lo, prod_hi;
  logic [62:0]   sol;
  logic [1:0]    stat_out;

  logic [DW-1:0] div_a, div_quo;
  logic [31:0]   div_b, div_rem;
  logic          div_done;
  logic [31:0]   mul_x, mul_y, m_in;
  logic [63:0]   mul_p, md64, cm64;
  logic [95:0]   lcm_full;
  logic [63:0]   r_sum;
  logic signed [33:0] s1_neg;
  logic [31:0]   s1_abs;
  logic signed [65:0] pm, ts;
  logic [32:0]   diff_w;

  crt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctl.div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .quo      (div_quo),
    .rem      (div_rem),
    .done     (div_done)
  );

  assign md64 = 64'(md);
  assign cm64 = 64'(cm);
  assign m_in = 32'(s_tdata[MODULUS_BITS-1:0]);

  always_comb begin
    div_a = '0;
    div_b = 32'd1;
    unique case (ctl.op)
      OP_RED:     begin div_a = 64'(r);   div_b = m;  end
      OP_GCD:     begin div_a = a0;       div_b = a1; end
      OP_RD_R:    begin div_a = 64'(cr);  div_b = d;  end
      OP_RD_CMP:  begin div_a = 64'(r);   div_b = d;  end
      OP_MD:      begin div_a = 64'(cm);  div_b = d;  end
      OP_MM:      begin div_a = 64'(m);   div_b = d;  end
      OP_RM:      begin div_a = 64'(cr);  div_b = m;  end
      OP_Q:       begin div_a = 64'(t);   div_b = d;  end
      OP_INV0:    begin div_a = md64;     div_b = mm; end
      OP_EUC_DIV: begin div_a = a0;       div_b = a1; end
      OP_K_DIV:   begin div_a = prod_lo;  div_b = mm; end
      default:    ;
    endcase
  end

  assign s1_neg = -s1;
  assign s1_abs = s1[33] ? s1_neg[31:0] : s1[31:0];

  always_comb begin
    mul_x = '0;
    mul_y = '0;
    unique case (ctl.op)
      OP_LCM_LO:  begin mul_x = md64[31:0];  mul_y = m;          end
      OP_LCM_HI:  begin mul_x = md64[63:32]; mul_y = m;          end
      OP_EUC_MUL: begin mul_x = qq;          mul_y = s1_abs;     end
      OP_K_MUL:   begin mul_x = q;           mul_y = s0[31:0];   end
      OP_KM_LO:   begin mul_x = k;           mul_y = cm64[31:0]; end
      OP_KM_HI:   begin mul_x = k;           mul_y = cm64[63:32]; end
      default:    ;
    endcase
  end

  assign mul_p    = mul_x * mul_y;
  assign lcm_full = {prod_hi, 32'b0} + {32'b0, prod_lo};
  assign r_sum    = cm64 - cm64 + 64'(cr) + prod_lo + {prod_hi[31:0], 32'b0};
  assign diff_w   = (r >= t) ? {1'b0, r - t} : {1'b0, r} + {1'b0, m} - {1'b0, t};

  always_comb begin
    pm = $signed({2'b00, prod_lo});
    if (s1[33]) pm = -pm;
    ts = 66'(s0) - pm;
  end

  always_comb begin
    if (sticky != STAT_OK) sol = '0;
    else if (cr == '0) sol = 63'(cm);
    else sol = 63'(cr);
  end
  assign stat_out = sticky;

  always_ff @(posedge clk) begin
    if (rst) begin
      cm        <= '0;
      cr        <= '0;
      in_system <= 1'b0;
      sticky    <= STAT_OK;
      m_tvalid  <= 1'b0;
    end else begin
      if (ctl.op == OP_EMIT) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      unique case (ctl.op)
        OP_LOAD: begin
          m    <= (m_in == '0) ? 32'd1 : m_in;
          r    <= 32'(s_tdata[32 +: MODULUS_BITS]);
          last <= s_tlast;
        end
        OP_RED: if (div_done) r <= div_rem;
        OP_SEED: begin
          in_system <= 1'b1;
          if ((64'(m) >> CB) != '0) begin
            sticky <= STAT_OVF;
            cm     <= '0;
            cr     <= '0;
          end else begin
            sticky <= STAT_OK;
            cm     <= CB'(m);
            cr     <= CB'(r);
          end
        end
        OP_GCD_INIT: begin
          a0 <= cm64;
          a1 <= m;
        end
        OP_GCD: if (div_done) begin
          d  <= a1;          // last divisor before a zero remainder is the gcd
          a0 <= 64'(a1);
          a1 <= div_rem;
        end
        OP_RD_R:      if (div_done) t <= div_rem;
        OP_RD_CMP:    if (div_done) nosol <= div_rem != t;
        OP_SET_NOSOL: sticky <= STAT_NOSOL;
        OP_MD:        if (div_done) md <= CB'(div_quo);
        OP_MM:        if (div_done) mm <= div_quo[31:0];
        OP_LCM_LO:    prod_lo <= mul_p;
        OP_LCM_HI:    prod_hi <= mul_p;
        OP_LCM_SUM: begin
          lcm <= lcm_full[CB-1:0];
          ovf <= (lcm_full >> CB) != '0;
        end
        OP_SET_OVF: sticky <= STAT_OVF;
        OP_RM:      if (div_done) t <= div_rem;
        OP_DIFF:    t <= diff_w[31:0];
        OP_Q:       if (div_done) q <= div_quo[31:0];
        OP_KZERO:   k <= '0;
        OP_INV0: if (div_done) begin
          a0 <= 64'(div_rem);
          a1 <= mm;
          s0 <= 34'sd1;
          s1 <= 34'sd0;
        end
        OP_EUC_DIV: if (div_done) begin
          qq <= div_quo[31:0];
          t  <= div_rem;
        end
        OP_EUC_MUL: prod_lo <= mul_p;
        OP_EUC_UPD: begin
          a0 <= 64'(a1);
          a1 <= t;
          s0 <= s1;
          s1 <= ts[33:0];
        end
        OP_INV_FIX: if (s0 < 0) s0 <= s0 + $signed({2'b00, mm});
        OP_K_MUL:   prod_lo <= mul_p;
        OP_K_DIV:   if (div_done) k <= div_rem;
        OP_KM_LO:   prod_lo <= mul_p;
        OP_KM_HI:   prod_hi <= mul_p;
        OP_COMMIT: begin
          cr <= r_sum[CB-1:0];
          cm <= lcm;
        end
        OP_EMIT: begin
          m_tdata   <= {7'b0, stat_out, sol};
          cm        <= '0;
          cr        <= '0;
          in_system <= 1'b0;
          sticky    <= STAT_OK;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    sts.div_done  = div_done;
    sts.rem_zero  = div_rem == '0;
    sts.t_zero    = t == '0;
    sts.in_system = in_system;
    sts.sticky_ok = sticky == STAT_OK;
    sts.nosol     = nosol;
    sts.ovf       = ovf;
    sts.mm_le1    = mm <= 32'd1;
    sts.last      = last;
    sts.out_free  = !m_tvalid || m_tready;
  end

endmodule

FILE: rtl/core/crt_general_merge.sv
`timescale 1ns / 1ps
// channel | dir | tdata fields (low bit up)             | side band
// s_*     | in  | modulus[31:0], remainder[63:32]       | tlast = last
// m_*     | out | solution[62:0], status[64:63], pad 0  | -
//
// One congruence at a time. The bulk of a merged item's work is the gcd and
// extended Euclid steps, whose divisions all run on the one bit-per-cycle divider.
// Reset clears the running system and any pending result.
// A finished result waits in the output register; a new item is still taken.

module crt_general_merge
  import crt_pkg::*;
#(
  parameter int MODULUS_BITS  = MODULUS_BITS_DEF,
  parameter int COMBINED_BITS = COMBINED_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // modulus, remainder
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata    // solution, status, zero pad
);

  ctl_t ctl;
  sts_t sts;

  crt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .ctl      (ctl)
  );

  crt_dpath #(
    .MODULUS_BITS  (MODULUS_BITS),
    .COMBINED_BITS (COMBINED_BITS)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .sts      (sts),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second beat taken while an item is in work");

  a_start_pulse: assert property (@(posedge clk) disable iff (rst)
    ctl.div_start |=> !ctl.div_start)
    else $error("divider restarted back to back");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[64:63] != 2'd3))
    else $error("undefined status code");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[64:63] != STAT_OK) |-> (m_tdata[62:0] == '0))
    else $error("solution not zero on error status");

endmodule
